/* src/asd_pkg.sv */
`default_nettype none
package asd_pkg;
    localparam int DW = 31;
    localparam int SW = 35;
    localparam int QW = 31;
    localparam int NW = 17;
endpackage
`default_nettype wire

/* src/asd_div.sv */
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module asd_div
    import asd_pkg::*;
#(
    parameter int W = DW,
    parameter int XW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    input  wire logic [XW-1:0] i_side,
    output logic               o_valid,
    output logic [W-1:0]       o_quot,
    output logic [W-1:0]       o_rem,
    output logic [XW-1:0]      o_side
);
    logic [W:0]    r_vld;
    logic [W-1:0]  r_rem  [W+1];
    logic [W-1:0]  r_quot [W+1];
    logic [W-1:0]  r_den  [W+1];
    logic [XW-1:0] r_side [W+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_rem[0]  = '0;
        r_quot[0] = i_num;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < W; k++) begin : g_st
        logic [W:0] n_t;
        logic       n_ge;
        always_comb begin
            n_t  = {r_rem[k], r_quot[k][W-1]};
            n_ge = n_t >= {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? W'(n_t - {1'b0, r_den[k]}) : n_t[W-1:0];
                r_quot[k+1] <= {r_quot[k][W-2:0], n_ge};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[W];
    assign o_quot  = r_quot[W];
    assign o_rem   = r_rem[W];
    assign o_side  = r_side[W];
endmodule
`default_nettype wire

/* src/asd_sqrt.sv */
`default_nettype none
// Pipelined digit-by-digit square root; gives n = (isqrt(1+8q)-1)/2.
module asd_sqrt
    import asd_pkg::*;
#(
    parameter int XW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [QW-1:0] i_q,
    input  wire logic [XW-1:0] i_side,
    output logic               o_valid,
    output logic [NW-1:0]      o_n,
    output logic [XW-1:0]      o_side
);
    localparam int ST = (SW + 1) / 2;
    localparam int RW = ST + 2;

    logic [ST:0]   r_vld;
    logic [SW:0]   r_x    [ST+1];
    logic [RW-1:0] r_rm   [ST+1];
    logic [ST-1:0] r_root [ST+1];
    logic [XW-1:0] r_side [ST+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_x[0]    = {2'b00, i_q, 3'b001};
        r_rm[0]   = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < ST; k++) begin : g_st
        logic [RW-1:0] n_t;
        logic [RW-1:0] n_trial;
        logic          n_ge;
        always_comb begin
            n_t     = {r_rm[k][RW-3:0], r_x[k][SW:SW-1]};
            n_trial = {r_root[k], 2'b01};
            n_ge    = n_t >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rm[k+1]   <= n_ge ? n_t - n_trial : n_t;
                r_root[k+1] <= {r_root[k][ST-2:0], n_ge};
                r_x[k+1]    <= {r_x[k][SW-2:0], 2'b00};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // The root is odd or even, so one is taken off before halving.
    assign o_valid = r_vld[ST];
    assign o_n     = NW'((r_root[ST] - ST'(1)) >> 1);
    assign o_side  = r_side[ST];
endmodule
`default_nettype wire

/* src/approach_speed_for_distance.sv */
`default_nettype none
// Channel   Dir  Payload
// s_axis    in   tdata[31:0] distance, tdata[63:32] decel_rate
// m_axis    out  tdata[30:0] speed, bit 31 zero
// Each request passes 83 register stages: two 31-stage dividers, the 18-stage square
// root, two multiply stages and the output register; one request enters per cycle
// unless stalled. Reset clears only valid bits. A stall freezes the whole pipeline
// in place; a one-entry skid register lets the input side keep running until full.
module approach_speed_for_distance
    import asd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // distance, decel_rate
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // speed
);
    localparam int XW = 2 * DW + 1;
    logic en;
    logic r_ov, r_sv;
    logic [DW-1:0] r_od, r_sd;

    // Pipeline advances whenever the skid register is empty.
    assign en = !r_sv;
    assign s_axis_tready = en;

    logic [31:0] d_raw, a_raw;
    logic        ok;
    assign d_raw = s_axis_tdata[31:0];
    assign a_raw = s_axis_tdata[63:32];
    assign ok = !d_raw[31] && d_raw != 0 && !a_raw[31] && a_raw != 0;

    logic          v1;
    logic [DW-1:0] q1, rm1;
    logic [XW-1:0] sd1;
    asd_div #(.W(DW), .XW(XW)) u_div_q (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s_axis_tvalid && en),
        .i_num(ok ? d_raw[DW-1:0] : '0), .i_den(ok ? a_raw[DW-1:0] : DW'(1)),
        .i_side({ok, d_raw[DW-1:0], a_raw[DW-1:0]}),
        .o_valid(v1), .o_quot(q1), .o_rem(rm1), .o_side(sd1)
    );

    logic          v2;
    logic [NW-1:0] n2;
    logic [XW-1:0] sd2;
    asd_sqrt #(.XW(XW)) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v1), .i_q(q1), .i_side(sd1),
        .o_valid(v2), .o_n(n2), .o_side(sd2)
    );

    // Stage 3: triangle number; stage 4: multiplies by a.
    logic          r_v3, r_v4;
    logic [NW-1:0] r_n3;
    logic [DW-1:0] r_tri3;
    logic [XW-1:0] r_s3, r_s4;
    logic [DW-1:0] r_used4, r_na4;
    logic [NW:0]   r_n14;
    logic [2*NW+1:0] n_tp;
    assign n_tp = {1'b0, n2} * {1'b0, NW'(n2 + NW'(1))};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v3 <= v2;
            r_v4 <= r_v3;
        end
        if (en) begin
            r_n3    <= n2;
            r_tri3  <= DW'(n_tp >> 1);
            r_s3    <= sd2;
            r_used4 <= DW'(r_tri3 * r_s3[DW-1:0]);
            r_na4   <= DW'(r_n3 * r_s3[DW-1:0]);
            r_n14   <= {1'b0, r_n3} + (NW+1)'(1);
            r_s4    <= r_s3;
        end
    end

    logic          v5;
    logic [DW-1:0] r5, rm5;
    logic [XW-1:0] sd5;
    asd_div #(.W(DW), .XW(XW)) u_div_r (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v4),
        .i_num(DW'(r_s4[2*DW-1:DW] - r_used4)), .i_den(DW'(r_n14)),
        .i_side({r_s4[XW-1], r_na4, r_s4[DW-1:0]}),
        .o_valid(v5), .o_quot(r5), .o_rem(rm5), .o_side(sd5)
    );

    logic [DW-1:0] n_sp;
    assign n_sp = sd5[XW-1] ? DW'(sd5[2*DW-1:DW] + r5) : '0;

    logic unused;
    assign unused = ^{rm1, rm5, sd5[DW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || m_axis_tready) begin
                r_ov <= r_sv || (v5 && en);
                r_sv <= 1'b0;
            end else if (v5 && en) begin
                r_sv <= 1'b1;
            end
        end
        if (!r_ov || m_axis_tready) begin
            r_od <= r_sv ? r_sd : n_sp;
        end else if (v5 && en) begin
            r_sd <= n_sp;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_od};
endmodule
`default_nettype wire

/* dv/approach_speed_for_distance_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module approach_speed_for_distance_tb;

    localparam int LATENCY     = 120;
    localparam int CYCLE_LIMIT = 400000;

    // Distance sits in the low half of the request word.
    typedef struct packed {
        logic signed [31:0] decel_rate;
        logic signed [31:0] distance;
    } t_approach_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // distance, decel_rate
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // speed, zero

    approach_speed_for_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_approach_req pending_reqs[$];
    logic [30:0]   expected_speeds[$];
    int            mismatches;
    int            results_seen;
    int            cycle_count;
    bit            quiet_phase;     // no random idling on either side
    bit            sender_hold;     // sender pauses while this is set
    int            hold_off_left;   // receiver stall, counted in cycles
    bit            hold_off_req;
    bit            s_taken;         // request accepted at the last rising edge

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [30:0] approach_speed(input t_approach_req req);
        logic [63:0] d, a, q, n, tri_num, used, left;
        if (req.distance <= 0 || req.decel_rate <= 0) return '0;
        d       = 64'(unsigned'(req.distance));
        a       = 64'(unsigned'(req.decel_rate));
        q       = d / a;
        n       = (floor_sqrt(64'd1 + 64'd8 * q) - 1) / 2;
        tri_num = (n * (n + 1)) / 2;
        used    = tri_num * a;
        left    = (used <= d) ? d - used : 64'd0;
        return 31'(n * a + left / (n + 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %0s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 64);
            1: return $urandom_range(1, 100000);
            2: return $urandom;
            3: return 32'h7FFF_FFFF - $urandom_range(0, 1000);
            4: return {1'b0, 31'($urandom)} >> $urandom_range(0, 30);
            default: return $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
        endcase
    endfunction

    // Sender: a request stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_taken) begin
            // hold the current request
        end else if (pending_reqs.size() != 0 && !sender_hold &&
                     (quiet_phase || $urandom_range(0, 99) >= 7)) begin
            s_axis_tdata  <= pending_reqs.pop_front();
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Prediction is made when the request is taken.
    always @(posedge i_clk) begin
        s_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_speeds.push_back(approach_speed(t_approach_req'(s_axis_tdata)));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_off_left <= 0;
        end else if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_axis_tready <= (hold_off_left == 1);
        end else begin
            m_axis_tready <= quiet_phase || $urandom_range(0, 99) >= 7;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_speeds.size() == 0) begin
                report_mismatch("result with no request waiting", m_axis_tdata, 0);
            end else begin
                logic [30:0] want;
                want = expected_speeds.pop_front();
                if (m_axis_tdata[30:0] !== want)
                    report_mismatch("speed", m_axis_tdata[30:0], want);
                if (m_axis_tdata[31] !== 1'b0)
                    report_mismatch("padding bit", m_axis_tdata[31], 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_speeds.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_req(input logic [31:0] d, input logic [31:0] a);
        t_approach_req req;
        req.distance   = d;
        req.decel_rate = a;
        pending_reqs.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_speeds.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        mismatches    = 0;
        results_seen  = 0;
        cycle_count   = 0;
        quiet_phase   = 1'b0;
        sender_hold   = 1'b0;
        hold_off_req  = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Edge cases: zero and negative inputs, extremes and small exact triangles.
        queue_req(0, 5);
        queue_req(5, 0);
        queue_req(32'h8000_0000, 3);
        queue_req(100, 32'h8000_0000);
        queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(32'h7FFF_FFFF, 1);
        queue_req(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_req(1, 32'h7FFF_FFFF);
        queue_req(1, 1);
        queue_req(3, 1);
        queue_req(6, 1);
        queue_req(10, 2);
        queue_req(9, 1);
        queue_req(32'h7FFF_FFFE, 2);
        queue_req(32'h5555_5555, 32'h2AAA_AAAA);
        queue_req(32'h2AAA_AAAA, 32'h5555_5555);
        queue_req(100, 7);
        queue_req(55, 1);
        wait_drained();

        for (int i = 0; i < 300; i++) queue_req(rand_value(), rand_value());

        // Receiver stalls for a long stretch while the sender keeps offering.
        hold_off_req = 1'b1;
        @(posedge i_clk);
        hold_off_req = 1'b0;
        for (int i = 0; i < 250; i++) queue_req(rand_value(), rand_value());
        wait_drained();

        quiet_phase = 1'b1;
        for (int i = 0; i < 200; i++) queue_req(rand_value(), rand_value());
        wait_drained();
        quiet_phase = 1'b0;

        // A last batch of random requests, then the bench waits until all results are back.
        for (int i = 0; i < 100; i++) queue_req(rand_value(), rand_value());
        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("covered %0d results over edge cases, random mixes, a long output stall",
                 results_seen);
        $display("and a stretch without idling; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_speeds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
